// ===== hdl/coin_change_dispenser_defines.svh =====
// Assertion macros shared by the coin change dispenser modules.
// Expects signals named clock and reset in the module that uses them.
`ifndef COIN_CHANGE_DISPENSER_DEFINES_SVH
`define COIN_CHANGE_DISPENSER_DEFINES_SVH

// same-cycle implication
`define CCD_ASSERT_IMP(name, pre, post) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("coin change dispenser: check failed");

// next-cycle implication
`define CCD_ASSERT_NEXT(name, pre, post) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("coin change dispenser: check failed");

`endif

// ===== hdl/ccd_pkg.sv =====
// Shared constants, coin tables and controller/datapath interface types
// for the coin change dispenser. No dependencies.
package ccd_pkg;

   localparam int NUM_DENOMS   = 6;
   localparam int IDX_WIDTH    = $clog2(NUM_DENOMS);
   localparam int STOCK_WIDTH  = 16;
   localparam int COUNT_WIDTH  = 8;
   localparam int AMOUNT_WIDTH = 16;
   localparam int GIVE_WIDTH   = 16;
   localparam int VALUE_WIDTH  = 9;
   localparam int RECIP_WIDTH  = 25;
   localparam int RECIP_SHIFT  = 28;
   localparam int PROD_WIDTH   = AMOUNT_WIDTH + RECIP_WIDTH;
   localparam int PAY_WIDTH    = AMOUNT_WIDTH + VALUE_WIDTH;
   localparam int SUM_WIDTH    = STOCK_WIDTH + 1;
   localparam int CMP_WIDTH    = (STOCK_WIDTH > AMOUNT_WIDTH) ? STOCK_WIDTH : AMOUNT_WIDTH;

   localparam logic KIND_PAY  = 1'b0;
   localparam logic KIND_LOAD = 1'b1;

   typedef logic [NUM_DENOMS-1:0][COUNT_WIDTH-1:0] count_array_type;
   typedef logic [NUM_DENOMS-1:0][GIVE_WIDTH-1:0]  give_array_type;

   typedef struct packed {
      logic load;
      logic div;
      logic pay;
      logic finish;
   } dp_cmd_type;

   typedef struct packed {
      logic rem_zero;
      logic last;
      logic out_free;
   } dp_status_type;

   // coin values, largest first
   function automatic logic [VALUE_WIDTH-1:0] coin_value(input logic [IDX_WIDTH-1:0] idx);
      logic [VALUE_WIDTH-1:0] v;
      unique case (idx)
         3'd0:    v = 9'd500;
         3'd1:    v = 9'd200;
         3'd2:    v = 9'd100;
         3'd3:    v = 9'd50;
         3'd4:    v = 9'd20;
         3'd5:    v = 9'd10;
         default: v = 9'd0;
      endcase
      return v;
   endfunction

   // ceil(2^RECIP_SHIFT / value): exact quotient for any 16-bit amount
   function automatic logic [RECIP_WIDTH-1:0] coin_recip(input logic [IDX_WIDTH-1:0] idx);
      logic [RECIP_WIDTH-1:0] r;
      unique case (idx)
         3'd0:    r = 25'd536871;
         3'd1:    r = 25'd1342178;
         3'd2:    r = 25'd2684355;
         3'd3:    r = 25'd5368710;
         3'd4:    r = 25'd13421773;
         3'd5:    r = 25'd26843546;
         default: r = 25'd0;
      endcase
      return r;
   endfunction

endpackage

// ===== hdl/coin_change_dispenser.sv =====
// Coin change dispenser. A request is accepted when the block is idle; its
// result reaches the output register after a divide step (reciprocal
// multiply) and a pay step per denomination from 500 down, stopping early
// once the change is paid, and a commit step that waits for a free output. The
// result waits in its own register, so the next request is taken while it
// is still stalled. Stock is all zero after reset. Uses ccd_pkg, ccd_ctrl, ccd_dp.
module coin_change_dispenser (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_kind,
   input  logic [ccd_pkg::AMOUNT_WIDTH-1:0]    req_change_amount,
   input  logic [ccd_pkg::COUNT_WIDTH-1:0]     req_count_500,
   input  logic [ccd_pkg::COUNT_WIDTH-1:0]     req_count_200,
   input  logic [ccd_pkg::COUNT_WIDTH-1:0]     req_count_100,
   input  logic [ccd_pkg::COUNT_WIDTH-1:0]     req_count_50,
   input  logic [ccd_pkg::COUNT_WIDTH-1:0]     req_count_20,
   input  logic [ccd_pkg::COUNT_WIDTH-1:0]     req_count_10,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_success,
   output logic [ccd_pkg::GIVE_WIDTH-1:0]      rsp_give_500,
   output logic [ccd_pkg::GIVE_WIDTH-1:0]      rsp_give_200,
   output logic [ccd_pkg::GIVE_WIDTH-1:0]      rsp_give_100,
   output logic [ccd_pkg::GIVE_WIDTH-1:0]      rsp_give_50,
   output logic [ccd_pkg::GIVE_WIDTH-1:0]      rsp_give_20,
   output logic [ccd_pkg::GIVE_WIDTH-1:0]      rsp_give_10
);

   ccd_pkg::dp_cmd_type      cmd;
   ccd_pkg::dp_status_type   status;
   ccd_pkg::count_array_type req_counts;
   ccd_pkg::give_array_type  rsp_gives;

   assign req_counts[0] = req_count_500;
   assign req_counts[1] = req_count_200;
   assign req_counts[2] = req_count_100;
   assign req_counts[3] = req_count_50;
   assign req_counts[4] = req_count_20;
   assign req_counts[5] = req_count_10;

   assign rsp_give_500 = rsp_gives[0];
   assign rsp_give_200 = rsp_gives[1];
   assign rsp_give_100 = rsp_gives[2];
   assign rsp_give_50  = rsp_gives[3];
   assign rsp_give_20  = rsp_gives[4];
   assign rsp_give_10  = rsp_gives[5];

   ccd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   ccd_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_kind          (req_kind),
      .req_change_amount (req_change_amount),
      .req_counts        (req_counts),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_success       (rsp_success),
      .rsp_gives         (rsp_gives)
   );

endmodule

// ===== hdl/ccd_ctrl.sv =====
// Sequencer for the coin change dispenser: accepts a request, steps the
// datapath through the denominations and commits. Uses ccd_pkg.
`include "coin_change_dispenser_defines.svh"

module ccd_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  ccd_pkg::dp_status_type status,
   output ccd_pkg::dp_cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_DIV    = 4'b0010,
      ST_PAY    = 4'b0100,
      ST_FINISH = 4'b1000
   } ctrl_state_type;

   ctrl_state_type state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_stall  = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (status.rem_zero) begin
               state_in = ST_FINISH;
            end else begin
               cmd.div  = 1'b1;
               state_in = ST_PAY;
            end
         end
         ST_PAY: begin
            cmd.pay  = 1'b1;
            state_in = status.last ? ST_FINISH : ST_DIV;
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `CCD_ASSERT_NEXT(a_accept_starts, req_valid && !req_stall, state_ff == ST_DIV)
   `CCD_ASSERT_NEXT(a_finish_waits, (state_ff == ST_FINISH) && !status.out_free,
                    state_ff == ST_FINISH)
   `CCD_ASSERT_IMP(a_one_cmd, 1'b1, $onehot0({cmd.load, cmd.div, cmd.pay, cmd.finish}))

endmodule

// ===== hdl/ccd_dp.sv =====
// Datapath for the coin change dispenser: stock, working counts, remainder,
// reciprocal divider, pay step and result register. Uses ccd_pkg.
`include "coin_change_dispenser_defines.svh"

module ccd_dp (
   input  logic                                  clock,
   input  logic                                  reset,
   input  ccd_pkg::dp_cmd_type                   cmd,
   output ccd_pkg::dp_status_type                status,
   input  logic                                  req_kind,
   input  logic [ccd_pkg::AMOUNT_WIDTH-1:0]      req_change_amount,
   input  ccd_pkg::count_array_type              req_counts,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_success,
   output ccd_pkg::give_array_type               rsp_gives
);

   logic [ccd_pkg::NUM_DENOMS-1:0][ccd_pkg::STOCK_WIDTH-1:0]  stock_ff, stock_in;
   logic [ccd_pkg::NUM_DENOMS-1:0][ccd_pkg::STOCK_WIDTH-1:0]  work_ff, work_in;
   logic [ccd_pkg::NUM_DENOMS-1:0][ccd_pkg::AMOUNT_WIDTH-1:0] give_ff, give_in;
   logic [ccd_pkg::AMOUNT_WIDTH-1:0] rem_ff, rem_in;
   logic [ccd_pkg::AMOUNT_WIDTH-1:0] quot_ff, quot_in;
   logic [ccd_pkg::IDX_WIDTH-1:0]    idx_ff, idx_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic                             success_ff, success_in;
   ccd_pkg::give_array_type          give_out_ff, give_out_in;

   logic [ccd_pkg::SUM_WIDTH-1:0]    sum;
   logic [ccd_pkg::PROD_WIDTH-1:0]   div_prod;
   logic [ccd_pkg::PAY_WIDTH-1:0]    pay_prod;
   logic [ccd_pkg::STOCK_WIDTH-1:0]  work_sel;
   logic [ccd_pkg::AMOUNT_WIDTH-1:0] pay_n;

   assign status.rem_zero = (rem_ff == '0);
   assign status.last     = (idx_ff == ccd_pkg::IDX_WIDTH'(ccd_pkg::NUM_DENOMS - 1));
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   assign work_sel = work_ff[idx_ff];
   assign div_prod = ccd_pkg::PROD_WIDTH'(rem_ff)
                   * ccd_pkg::PROD_WIDTH'(ccd_pkg::coin_recip(idx_ff));
   assign pay_n    = (ccd_pkg::CMP_WIDTH'(quot_ff) > ccd_pkg::CMP_WIDTH'(work_sel))
                   ? ccd_pkg::AMOUNT_WIDTH'(work_sel) : quot_ff;
   assign pay_prod = ccd_pkg::PAY_WIDTH'(pay_n)
                   * ccd_pkg::PAY_WIDTH'(ccd_pkg::coin_value(idx_ff));

   always_comb begin
      stock_in     = stock_ff;
      work_in      = work_ff;
      give_in      = give_ff;
      rem_in       = rem_ff;
      quot_in      = quot_ff;
      idx_in       = idx_ff;
      success_in   = success_ff;
      give_out_in  = give_out_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      sum          = '0;

      // take request: working counts, remainder
      if (cmd.load) begin
         for (int i = 0; i < ccd_pkg::NUM_DENOMS; i++) begin
            sum = ccd_pkg::SUM_WIDTH'(stock_ff[i]) + ccd_pkg::SUM_WIDTH'(req_counts[i]);
            if (req_kind == ccd_pkg::KIND_LOAD) begin
               work_in[i] = ccd_pkg::STOCK_WIDTH'(req_counts[i]);
            end else begin
               work_in[i] = sum[ccd_pkg::STOCK_WIDTH] ? '1 : sum[ccd_pkg::STOCK_WIDTH-1:0];
            end
         end
         give_in = '0;
         rem_in  = (req_kind == ccd_pkg::KIND_LOAD) ? '0 : req_change_amount;
         idx_in  = '0;
      end

      if (cmd.div) begin
         quot_in = ccd_pkg::AMOUNT_WIDTH'(div_prod >> ccd_pkg::RECIP_SHIFT);
      end

      if (cmd.pay) begin
         give_in[idx_ff] = pay_n;
         rem_in          = rem_ff - ccd_pkg::AMOUNT_WIDTH'(pay_prod);
         idx_in          = idx_ff + ccd_pkg::IDX_WIDTH'(1);
      end

      // commit stock on success and fill result register
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
         success_in   = status.rem_zero;
         for (int i = 0; i < ccd_pkg::NUM_DENOMS; i++) begin
            give_out_in[i] = status.rem_zero ? ccd_pkg::GIVE_WIDTH'(give_ff[i]) : '0;
            if (status.rem_zero) begin
               stock_in[i] = work_ff[i] - ccd_pkg::STOCK_WIDTH'(give_ff[i]);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stock_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         stock_ff     <= stock_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff     <= work_in;
      give_ff     <= give_in;
      rem_ff      <= rem_in;
      quot_ff     <= quot_in;
      idx_ff      <= idx_in;
      success_ff  <= success_in;
      give_out_ff <= give_out_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_success = success_ff;
   assign rsp_gives   = give_out_ff;

   `CCD_ASSERT_NEXT(a_finish_shows, cmd.finish, rsp_valid_ff)
   `CCD_ASSERT_NEXT(a_pay_rem_down, cmd.pay, rem_ff <= $past(rem_ff))
   `CCD_ASSERT_IMP(a_fail_no_give, rsp_valid_ff && !success_ff, give_out_ff == '0)

endmodule
